[hw/rtl/fsrm_pkg.sv]
// Package with shared types and constants of the frame slot ring manager.
package fsrm_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int SLOT_W = 3;
  localparam int OCC_W = 4;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_WRITE = 2'd1,
    ST_READY = 2'd2,
    ST_PROC  = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    ACT_GET_WRITE = 3'd0,
    ACT_COMMIT    = 3'd1,
    ACT_GET_READ  = 3'd2,
    ACT_RELEASE   = 3'd3,
    ACT_RECORD    = 3'd4,
    ACT_STATUS    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CFG_INTERVAL  = 2'd0,
    CFG_MIN_FRAME = 2'd1,
    CFG_DROP_LIM  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_START,
    FSM_DIV_AVG,
    FSM_DIV_RATE,
    FSM_FLAG,
    FSM_OUT
  } fsm_st_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
    logic avg_start;
    logic rate_start;
    logic div_step;
    logic flag;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } ctl_sts_t;

  localparam logic [31:0] PERMILLE = 32'd1000;

endpackage

[hw/rtl/fsrm_ctrl.sv]
// Controller state machine sequencing one item through update, divider load, two divisions, flag and output.
module fsrm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fsrm_pkg::ctl_sts_t  sts,
  output fsrm_pkg::ctl_cmd_t  cmd
);

  fsrm_pkg::fsm_st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsrm_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsrm_pkg::FSM_IDLE: begin
        if (in_valid) state_nxt = fsrm_pkg::FSM_EXEC;
      end
      fsrm_pkg::FSM_EXEC: state_nxt = fsrm_pkg::FSM_START;
      fsrm_pkg::FSM_START: state_nxt = fsrm_pkg::FSM_DIV_AVG;
      fsrm_pkg::FSM_DIV_AVG: begin
        if (sts.div_done) state_nxt = fsrm_pkg::FSM_DIV_RATE;
      end
      fsrm_pkg::FSM_DIV_RATE: begin
        if (sts.div_done) state_nxt = fsrm_pkg::FSM_FLAG;
      end
      fsrm_pkg::FSM_FLAG: state_nxt = fsrm_pkg::FSM_OUT;
      fsrm_pkg::FSM_OUT: begin
        if (!out_stall) state_nxt = fsrm_pkg::FSM_IDLE;
      end
      default: state_nxt = fsrm_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      fsrm_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      fsrm_pkg::FSM_EXEC: cmd.exec = 1'b1;
      fsrm_pkg::FSM_START: cmd.avg_start = 1'b1;
      fsrm_pkg::FSM_DIV_AVG: begin
        cmd.div_step = !sts.div_done;
        cmd.rate_start = sts.div_done;
      end
      fsrm_pkg::FSM_DIV_RATE: cmd.div_step = !sts.div_done;
      fsrm_pkg::FSM_FLAG: cmd.flag = 1'b1;
      fsrm_pkg::FSM_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fsrm_pkg::FSM_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_after_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == fsrm_pkg::FSM_FLAG)
    else $error("result shown without flag step");
  a_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.avg_start && cmd.rate_start))
    else $error("two divisions started at once");

endmodule

[hw/rtl/fsrm_div.sv]
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit a cycle while step is high.
module fsrm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        step,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign done = (cnt_r == 7'd0);
  assign quotient = quo_r;

  always_comb begin
    shifted = {rem_r[31:0], quo_r[63]};
    trial = shifted - {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (step && !done) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 7'd0 && dvs_r != 32'd0) |-> rem_r < {1'b0, dvs_r})
    else $error("remainder escaped divisor bound");

endmodule

[hw/rtl/fsrm_dp.sv]
// Datapath holding the slot ring, totals, configuration and the result register.
module fsrm_dp #(
  parameter int SLOTS = fsrm_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fsrm_pkg::ctl_cmd_t cmd,
  output fsrm_pkg::ctl_sts_t sts,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         in_action,
  input  logic [31:0]        in_stamp_ms,
  input  logic [31:0]        in_proc_time_ms,
  output logic               out_granted,
  output logic [2:0]         out_slot,
  output logic [7:0]         out_slot_frame_no,
  output logic [31:0]        out_slot_stamp_ms,
  output logic [3:0]         out_occupied,
  output logic               out_dropped_now,
  output logic [31:0]        out_avg_time_ms,
  output logic [9:0]         out_drop_permille,
  output logic               out_degraded
);

  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);
  localparam logic [CW-1:0] NEAR = CW'(SLOTS - 1);

  fsrm_pkg::slot_st_t st_r [SLOTS];
  logic [31:0] stamp_mem [SLOTS];
  logic [7:0]  frame_mem [SLOTS];

  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] occ_r;
  logic [31:0]   ftot_r, fdrop_r, tmax_r;
  logic [63:0]   tsum_r;
  logic [15:0]   intv_r, minf_r;
  logic [9:0]    dlim_r;

  logic [2:0]  act_r;
  logic [31:0] stamp_in_r, ptime_r;

  logic          g_r, drop_r;
  logic [PW-1:0] slot_r;
  logic [7:0]    fno_r;
  logic [31:0]   fst_r, avg_r;
  logic [9:0]    rate_r;
  logic          deg_r;

  logic        div_start;
  logic [63:0] div_dvd, div_q;
  logic        div_done;
  logic [41:0] drop_x1000;
  logic [31:0] thr_r;
  logic [33:0] thr_prod;

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
    nxt_ptr = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  assign sts.div_done = div_done;
  assign drop_x1000 = {10'd0, fdrop_r} * 42'd1000;
  assign div_start = cmd.avg_start || cmd.rate_start;
  assign div_dvd = cmd.avg_start ? tsum_r : {22'd0, drop_x1000};

  // The interval times 8/10 is 4x/5, taken as a reciprocal multiply that is exact
  // for every 16-bit interval.
  assign thr_prod = {16'd0, intv_r, 2'b00} * 34'd52429;

  fsrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .step     (cmd.div_step),
    .dividend (div_dvd),
    .divisor  (ftot_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r <= 16'd33;
      minf_r <= 16'd100;
      dlim_r <= 10'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fsrm_pkg::CFG_INTERVAL:  intv_r <= cfg_data;
        fsrm_pkg::CFG_MIN_FRAME: minf_r <= cfg_data;
        fsrm_pkg::CFG_DROP_LIM:  dlim_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      stamp_in_r <= in_stamp_ms;
      ptime_r <= in_proc_time_ms;
    end
    thr_r <= {16'd0, thr_prod[33:18]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i] <= fsrm_pkg::ST_EMPTY;
        stamp_mem[i] <= '0;
        frame_mem[i] <= '0;
      end
      wp_r <= '0;
      rp_r <= '0;
      occ_r <= '0;
      ftot_r <= '0;
      fdrop_r <= '0;
      tmax_r <= '0;
      tsum_r <= '0;
    end else if (cmd.exec) begin
      case (act_r)
        fsrm_pkg::ACT_GET_WRITE: begin
          if (st_r[wp_r] == fsrm_pkg::ST_EMPTY) begin
            st_r[wp_r] <= fsrm_pkg::ST_WRITE;
          end else if (occ_r >= NEAR && st_r[rp_r] == fsrm_pkg::ST_READY) begin
            rp_r <= nxt_ptr(rp_r);
            if (occ_r != '0) occ_r <= occ_r - CW'(1);
            fdrop_r <= fdrop_r + 32'd1;
            st_r[rp_r] <= (rp_r == wp_r) ? fsrm_pkg::ST_WRITE : fsrm_pkg::ST_EMPTY;
          end
        end
        fsrm_pkg::ACT_COMMIT: begin
          if (st_r[wp_r] == fsrm_pkg::ST_WRITE) begin
            stamp_mem[wp_r] <= stamp_in_r;
            frame_mem[wp_r] <= ftot_r[7:0];
            st_r[wp_r] <= fsrm_pkg::ST_READY;
            if (occ_r < FULL) occ_r <= occ_r + CW'(1);
            ftot_r <= ftot_r + 32'd1;
            wp_r <= nxt_ptr(wp_r);
          end
        end
        fsrm_pkg::ACT_GET_READ: begin
          if (occ_r != '0 && st_r[rp_r] == fsrm_pkg::ST_READY) begin
            st_r[rp_r] <= fsrm_pkg::ST_PROC;
          end
        end
        fsrm_pkg::ACT_RELEASE: begin
          if (st_r[rp_r] == fsrm_pkg::ST_PROC) begin
            st_r[rp_r] <= fsrm_pkg::ST_EMPTY;
            rp_r <= nxt_ptr(rp_r);
            if (occ_r != '0) occ_r <= occ_r - CW'(1);
          end
        end
        fsrm_pkg::ACT_RECORD: begin
          tsum_r <= tsum_r + {32'd0, ptime_r};
          if (ptime_r > tmax_r) tmax_r <= ptime_r;
        end
        default: ;
      endcase
    end
  end

  // Per-item result fields: grant, slot and drop from the state before the update, average and rate from the divider.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      g_r <= 1'b0;
      drop_r <= 1'b0;
      slot_r <= '0;
      fno_r <= '0;
      fst_r <= '0;
      case (act_r)
        fsrm_pkg::ACT_GET_WRITE: begin
          if (st_r[wp_r] == fsrm_pkg::ST_EMPTY) begin
            g_r <= 1'b1;
            slot_r <= wp_r;
          end else if (occ_r >= NEAR && st_r[rp_r] == fsrm_pkg::ST_READY) begin
            drop_r <= 1'b1;
            if (rp_r == wp_r) begin
              g_r <= 1'b1;
              slot_r <= wp_r;
            end
          end
        end
        fsrm_pkg::ACT_COMMIT: begin
          if (st_r[wp_r] == fsrm_pkg::ST_WRITE) begin
            g_r <= 1'b1;
            slot_r <= wp_r;
          end
        end
        fsrm_pkg::ACT_GET_READ: begin
          if (occ_r != '0 && st_r[rp_r] == fsrm_pkg::ST_READY) begin
            g_r <= 1'b1;
            slot_r <= rp_r;
            fno_r <= frame_mem[rp_r];
            fst_r <= stamp_mem[rp_r];
          end
        end
        fsrm_pkg::ACT_RELEASE: begin
          if (st_r[rp_r] == fsrm_pkg::ST_PROC) begin
            g_r <= 1'b1;
            slot_r <= rp_r;
          end
        end
        default: ;
      endcase
    end
    if (cmd.rate_start) begin
      avg_r <= (ftot_r == '0) ? '0 :
               (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
    end
    if (cmd.flag) begin
      rate_r <= (ftot_r == '0) ? '0 :
                (div_q > 64'd1000) ? 10'd1000 : div_q[9:0];
    end
  end

  logic [9:0] rate_c;
  assign rate_c = (ftot_r == '0) ? '0 : (div_q > 64'd1000) ? 10'd1000 : div_q[9:0];

  always_ff @(posedge clk) begin
    if (cmd.flag) begin
      deg_r <= (ftot_r >= {16'd0, minf_r}) &&
               (avg_r > thr_r || tmax_r > {16'd0, intv_r} || rate_c > dlim_r);
    end
  end

  assign out_granted = g_r;
  assign out_slot = 3'(slot_r);
  assign out_slot_frame_no = fno_r;
  assign out_slot_stamp_ms = fst_r;
  assign out_occupied = 4'(occ_r);
  assign out_dropped_now = drop_r;
  assign out_avg_time_ms = avg_r;
  assign out_drop_permille = rate_r;
  assign out_degraded = deg_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL)
    else $error("occupied count above ring size");
  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == fsrm_pkg::ACT_COMMIT && st_r[wp_r] == fsrm_pkg::ST_WRITE)
    |=> ftot_r == $past(ftot_r) + 32'd1)
    else $error("commit did not count a frame");

endmodule

[hw/rtl/frame_slot_ring_manager_core.sv]
// Frame slot ring manager: controller, datapath and the port boundary.
// The result is offered after an update step, a divider load step, two serial
// divisions on one shared divider (a shift-subtract step per quotient bit and a
// hand-off step each) and a flag step. One item is in flight at a time; the next
// is taken in the cycle after the result leaves, and a stalled output holds it back.
// Synchronous active-low reset empties every slot, clears pointers and totals and
// loads the register defaults.
module frame_slot_ring_manager_core #(
  parameter int SLOTS = fsrm_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_stamp_ms,
  input  logic [31:0] in_proc_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_slot_frame_no,
  output logic [31:0] out_slot_stamp_ms,
  output logic [3:0]  out_occupied,
  output logic        out_dropped_now,
  output logic [31:0] out_avg_time_ms,
  output logic [9:0]  out_drop_permille,
  output logic        out_degraded
);

  fsrm_pkg::ctl_cmd_t cmd;
  fsrm_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  fsrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsrm_dp #(.SLOTS(SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_action         (in_action),
    .in_stamp_ms       (in_stamp_ms),
    .in_proc_time_ms   (in_proc_time_ms),
    .out_granted       (out_granted),
    .out_slot          (out_slot),
    .out_slot_frame_no (out_slot_frame_no),
    .out_slot_stamp_ms (out_slot_stamp_ms),
    .out_occupied      (out_occupied),
    .out_dropped_now   (out_dropped_now),
    .out_avg_time_ms   (out_avg_time_ms),
    .out_drop_permille (out_drop_permille),
    .out_degraded      (out_degraded)
  );

endmodule

[sim/tb_frame_slot_ring_manager_core.sv]
// Self-checking testbench for the frame slot ring manager core.
module tb_frame_slot_ring_manager_core;

  localparam int NSLOT = 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        granted;
    logic [2:0]  slot;
    logic [7:0]  frame_no;
    logic [31:0] stamp;
    logic [3:0]  occupied;
    logic        dropped;
    logic [31:0] avg;
    logic [9:0]  permille;
    logic        degraded;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [31:0] in_stamp_ms = '0;
  logic [31:0] in_proc_time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_granted;
  logic [2:0]  out_slot;
  logic [7:0]  out_slot_frame_no;
  logic [31:0] out_slot_stamp_ms;
  logic [3:0]  out_occupied;
  logic        out_dropped_now;
  logic [31:0] out_avg_time_ms;
  logic [9:0]  out_drop_permille;
  logic        out_degraded;

  frame_slot_ring_manager_core DUT (.*);

  always #5 clk = ~clk;

  fsrm_pkg::slot_st_t ring_st [NSLOT];
  logic [31:0] ring_stamp [NSLOT];
  logic [7:0]  ring_frame [NSLOT];
  logic [2:0]  wr_idx, rd_idx;
  logic [3:0]  occ_cnt;
  logic [31:0] frame_cnt, drop_cnt, max_time, interval_reg, min_frames_reg;
  logic [9:0]  drop_limit_reg;
  logic [63:0] time_total;

  ring_result_t pending_results[$];
  int  mismatches = 0;
  bit  rx_idle_on = 1'b1;
  bit  tx_idle_on = 1'b1;
  int  hold_off = 0;
  int  hold_reqs = 0;
  int  hold_done = 0;
  int  quiet_cycles = 0;

  function automatic ring_result_t model_ring(logic [2:0] act, logic [31:0] stamp,
                                              logic [31:0] ptime);
    ring_result_t r;
    logic [63:0] q;
    r = '0;
    case (act)
      fsrm_pkg::ACT_GET_WRITE: begin
        if (ring_st[wr_idx] != fsrm_pkg::ST_EMPTY && occ_cnt >= 4'(NSLOT - 1) &&
            ring_st[rd_idx] == fsrm_pkg::ST_READY) begin
          ring_st[rd_idx] = fsrm_pkg::ST_EMPTY;
          rd_idx = rd_idx + 3'd1;
          if (occ_cnt > 0) occ_cnt--;
          drop_cnt++;
          r.dropped = 1'b1;
        end
        if (ring_st[wr_idx] == fsrm_pkg::ST_EMPTY) begin
          ring_st[wr_idx] = fsrm_pkg::ST_WRITE;
          r.granted = 1'b1;
          r.slot = wr_idx;
        end
      end
      fsrm_pkg::ACT_COMMIT: begin
        if (ring_st[wr_idx] == fsrm_pkg::ST_WRITE) begin
          ring_stamp[wr_idx] = stamp;
          ring_frame[wr_idx] = frame_cnt[7:0];
          ring_st[wr_idx] = fsrm_pkg::ST_READY;
          if (occ_cnt < 4'(NSLOT)) occ_cnt++;
          frame_cnt++;
          r.granted = 1'b1;
          r.slot = wr_idx;
          wr_idx = wr_idx + 3'd1;
        end
      end
      fsrm_pkg::ACT_GET_READ: begin
        if (occ_cnt != 0 && ring_st[rd_idx] == fsrm_pkg::ST_READY) begin
          ring_st[rd_idx] = fsrm_pkg::ST_PROC;
          r.granted = 1'b1;
          r.slot = rd_idx;
          r.frame_no = ring_frame[rd_idx];
          r.stamp = ring_stamp[rd_idx];
        end
      end
      fsrm_pkg::ACT_RELEASE: begin
        if (ring_st[rd_idx] == fsrm_pkg::ST_PROC) begin
          ring_st[rd_idx] = fsrm_pkg::ST_EMPTY;
          r.granted = 1'b1;
          r.slot = rd_idx;
          rd_idx = rd_idx + 3'd1;
          if (occ_cnt > 0) occ_cnt--;
        end
      end
      fsrm_pkg::ACT_RECORD: begin
        time_total += {32'd0, ptime};
        if (ptime > max_time) max_time = ptime;
      end
      default: ;
    endcase
    r.occupied = occ_cnt;
    if (frame_cnt != 0) begin
      q = time_total / {32'd0, frame_cnt};
      r.avg = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      q = ({32'd0, drop_cnt} * 64'd1000) / {32'd0, frame_cnt};
      r.permille = (q > 64'd1000) ? 10'd1000 : q[9:0];
    end
    r.degraded = (frame_cnt >= min_frames_reg) &&
                 ({32'd0, r.avg} > ({32'd0, interval_reg} * 8) / 10 ||
                  max_time > interval_reg || r.permille > drop_limit_reg);
    return r;
  endfunction

  task automatic send_item(logic [2:0] act, logic [31:0] stamp, logic [31:0] ptime);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_stamp_ms <= stamp;
    in_proc_time_ms <= ptime;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(model_ring(act, stamp, ptime));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(fsrm_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      fsrm_pkg::CFG_INTERVAL:  interval_reg = {16'd0, val};
      fsrm_pkg::CFG_MIN_FRAME: min_frames_reg = {16'd0, val};
      default:                 drop_limit_reg = val[9:0];
    endcase
  endtask

  task automatic send_random(int n);
    int k;
    int unsigned sel;
    logic [2:0] a;
    logic [31:0] pt;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 8) a = fsrm_pkg::ACT_GET_WRITE;
      else if (sel == 9) a = fsrm_pkg::ACT_COMMIT;
      else a = 3'(sel);
      case ($urandom_range(0, 3))
        0: pt = $urandom();
        1: pt = $urandom_range(0, 60);
        default: pt = $urandom_range(0, 40);
      endcase
      send_item(a, $urandom(), pt);
    end
  endtask

  task automatic test_directed();
    int k;
    send_item(fsrm_pkg::ACT_COMMIT, 32'h1, 32'd0);
    send_item(fsrm_pkg::ACT_GET_READ, 32'd0, 32'd0);
    send_item(fsrm_pkg::ACT_RELEASE, 32'd0, 32'd0);
    send_item(fsrm_pkg::ACT_STATUS, 32'd0, 32'd0);
    send_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 32'd0, 32'd0);
    for (k = 0; k < 9; k++) begin
      send_item(fsrm_pkg::ACT_GET_WRITE, 32'd0, 32'd0);
      send_item(fsrm_pkg::ACT_COMMIT, (k == 0) ? 32'hFFFF_FFFF : 32'h0, 32'd0);
    end
    send_item(fsrm_pkg::ACT_GET_WRITE, 32'd0, 32'd0);
    send_item(fsrm_pkg::ACT_GET_READ, 32'd0, 32'd0);
    send_item(fsrm_pkg::ACT_RELEASE, 32'd0, 32'd0);
    send_item(fsrm_pkg::ACT_RECORD, 32'd0, 32'hFFFF_FFFF);
    send_item(fsrm_pkg::ACT_RECORD, 32'd0, 32'd0);
    drain_results();
  endtask

  task automatic test_config_sweep();
    write_reg(fsrm_pkg::CFG_INTERVAL, 16'hFFFF);
    write_reg(fsrm_pkg::CFG_MIN_FRAME, 16'h0);
    write_reg(fsrm_pkg::CFG_DROP_LIM, 16'd1000);
    send_random(350);
    drain_results();
    write_reg(fsrm_pkg::CFG_INTERVAL, 16'd0);
    write_reg(fsrm_pkg::CFG_MIN_FRAME, 16'hFFFF);
    write_reg(fsrm_pkg::CFG_DROP_LIM, 16'hFC00);
    send_random(350);
    drain_results();
    write_reg(fsrm_pkg::CFG_INTERVAL, 16'd1);
    write_reg(fsrm_pkg::CFG_MIN_FRAME, 16'd5);
    write_reg(fsrm_pkg::CFG_DROP_LIM, 16'd300);
    send_random(350);
    drain_results();
    write_reg(fsrm_pkg::CFG_INTERVAL, 16'd40);
    write_reg(fsrm_pkg::CFG_MIN_FRAME, 16'd20);
    write_reg(fsrm_pkg::CFG_DROP_LIM, 16'h03FF);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    send_random(12);
    drain_results();
  endtask

  task automatic test_steady();
    send_random(500);
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    send_random(150);
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      hold_off <= 400;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_off <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    ring_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_granted !== exp_r.granted) begin
          $error("granted exp %0h got %0h", exp_r.granted, out_granted); mismatches++;
        end
        if (out_slot !== exp_r.slot) begin
          $error("slot exp %0h got %0h", exp_r.slot, out_slot); mismatches++;
        end
        if (out_slot_frame_no !== exp_r.frame_no) begin
          $error("slot_frame_no exp %0h got %0h", exp_r.frame_no, out_slot_frame_no);
          mismatches++;
        end
        if (out_slot_stamp_ms !== exp_r.stamp) begin
          $error("slot_stamp_ms exp %0h got %0h", exp_r.stamp, out_slot_stamp_ms);
          mismatches++;
        end
        if (out_occupied !== exp_r.occupied) begin
          $error("occupied exp %0h got %0h", exp_r.occupied, out_occupied); mismatches++;
        end
        if (out_dropped_now !== exp_r.dropped) begin
          $error("dropped_now exp %0h got %0h", exp_r.dropped, out_dropped_now);
          mismatches++;
        end
        if (out_avg_time_ms !== exp_r.avg) begin
          $error("avg_time_ms exp %0h got %0h", exp_r.avg, out_avg_time_ms); mismatches++;
        end
        if (out_drop_permille !== exp_r.permille) begin
          $error("drop_permille exp %0h got %0h", exp_r.permille, out_drop_permille);
          mismatches++;
        end
        if (out_degraded !== exp_r.degraded) begin
          $error("degraded exp %0h got %0h", exp_r.degraded, out_degraded); mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < NSLOT; k++) begin
      ring_st[k] = fsrm_pkg::ST_EMPTY;
      ring_stamp[k] = '0;
      ring_frame[k] = '0;
    end
    wr_idx = '0; rd_idx = '0; occ_cnt = '0;
    frame_cnt = '0; drop_cnt = '0; max_time = '0; time_total = '0;
    interval_reg = 32'd33; min_frames_reg = 32'd100; drop_limit_reg = 10'd50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_steady();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
